// ===== rtl/rgb565_pixel_raster_op_macros.svh =====
// Assertion macros shared by the raster-op checker.
`ifndef RGB565_PIXEL_RASTER_OP_MACROS_SVH
`define RGB565_PIXEL_RASTER_OP_MACROS_SVH

// Property checked only while out of reset
`define ROP_ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Property checked on every edge, reset included
`define ROP_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rgb_rop_pkg.sv =====
// Shared types, codes and constants of the RGB565 raster-op block.
package rgb_rop_pkg;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_ALPHA  = 3'd0,
        OP_SINGLE = 3'd1,
        OP_LIGHT  = 3'd2,
        OP_ADD    = 3'd3,
        OP_GRAY   = 3'd4,
        OP_FILL   = 3'd5
    } op_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPREAD_MASK = 3'd0;
    localparam logic [2:0] CFG_RED_SHIFT   = 3'd1;
    localparam logic [2:0] CFG_GREEN_SHIFT = 3'd2;
    localparam logic [2:0] CFG_GREEN_MASK  = 3'd3;
    localparam logic [2:0] CFG_BLUE_MASK   = 3'd4;
    localparam logic [2:0] CFG_SRC_KEY     = 3'd5;
    localparam logic [2:0] CFG_BLEND_COLOR = 3'd6;

    // Register reset values
    localparam logic [31:0] RST_SPREAD_MASK = 32'h07E0_F81F;
    localparam logic [3:0]  RST_RED_SHIFT   = 4'd11;
    localparam logic [3:0]  RST_GREEN_SHIFT = 4'd5;
    localparam logic [15:0] RST_GREEN_MASK  = 16'h07E0;
    localparam logic [15:0] RST_BLUE_MASK   = 16'h001F;
    localparam logic [15:0] RST_SRC_KEY     = 16'h0000;
    localparam logic [15:0] RST_BLEND_COLOR = 16'h0000;

    // Alpha that leaves the destination untouched, and the full weight
    localparam logic [4:0] ALPHA_KEEP  = 5'd31;
    localparam logic [5:0] ALPHA_FULL  = 6'd32;
    localparam int         BLEND_SHIFT = 5;

    // Divide by ten: x < 2^20, floor(x/10) = (x * ceil(2^24/10)) >> 24
    localparam int          GRAY_SUM_W  = 20;
    localparam int          GRAY_RCP_W  = 21;
    localparam int          GRAY_SHIFT  = 24;
    localparam logic [20:0] GRAY_RCP    = 21'd1677722;

    // Result source selected in the last stage
    typedef enum logic [1:0] {
        SEL_DIRECT = 2'd0,
        SEL_BLEND  = 2'd1,
        SEL_ADD    = 2'd2,
        SEL_GRAY   = 2'd3
    } sel_t;

    typedef struct packed {
        logic [31:0] spread_mask;
        logic [3:0]  red_shift;
        logic [3:0]  green_shift;
        logic [15:0] green_mask;
        logic [15:0] blue_mask;
        logic [15:0] src_key;
        logic [15:0] blend_color;
    } cfg_t;

    // Decoded item after the first stage
    typedef struct packed {
        sel_t        sel;
        logic        we;
        logic [15:0] direct_px;
        logic [31:0] spread_d;
        logic [31:0] spread_s;
        logic [15:0] wgt_d;
        logic [5:0]  wgt_s;
        logic [19:0] gray_sum;
    } prep_t;

    // Products after the second stage
    typedef struct packed {
        sel_t        sel;
        logic        we;
        logic [15:0] direct_px;
        logic [31:0] prod_d;
        logic [31:0] prod_s;
        logic [15:0] gray_t;
    } prod_t;

endpackage

// ===== rtl/rgb_rop_cfg.sv =====
// Configuration register file of the raster-op block.
module rgb_rop_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output rgb_rop_pkg::cfg_t   cfg
);
    import rgb_rop_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SPREAD_MASK: cfg_next.spread_mask = cfg_wdata;
                CFG_RED_SHIFT:   cfg_next.red_shift   = cfg_wdata[3:0];
                CFG_GREEN_SHIFT: cfg_next.green_shift = cfg_wdata[3:0];
                CFG_GREEN_MASK:  cfg_next.green_mask  = cfg_wdata[15:0];
                CFG_BLUE_MASK:   cfg_next.blue_mask   = cfg_wdata[15:0];
                CFG_SRC_KEY:     cfg_next.src_key     = cfg_wdata[15:0];
                CFG_BLEND_COLOR: cfg_next.blend_color = cfg_wdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.spread_mask <= RST_SPREAD_MASK;
            cfg_reg.red_shift   <= RST_RED_SHIFT;
            cfg_reg.green_shift <= RST_GREEN_SHIFT;
            cfg_reg.green_mask  <= RST_GREEN_MASK;
            cfg_reg.blue_mask   <= RST_BLUE_MASK;
            cfg_reg.src_key     <= RST_SRC_KEY;
            cfg_reg.blend_color <= RST_BLEND_COLOR;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rgb_rop_prep.sv =====
// Stage 1: op decode, keying, channel spreading, weights and gray sum.
module rgb_rop_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  rgb_rop_pkg::cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_op,
    input  logic [15:0]         in_src,
    input  logic [15:0]         in_dst,
    input  logic [4:0]          in_alpha,
    output logic                out_valid,
    input  logic                out_ready,
    output rgb_rop_pkg::prep_t  out_data
);
    import rgb_rop_pkg::*;

    logic        valid_reg;
    prep_t       data_reg;
    prep_t       data_next;
    logic        keyed;
    logic [15:0] red_v;
    logic [15:0] green_v;
    logic [15:0] blue_v;

    assign keyed = (cfg.src_key != 16'h0000) && (in_src == cfg.src_key);

    // Gray channel extraction
    assign red_v   = in_src >> cfg.red_shift;
    assign green_v = (in_src & cfg.green_mask) >> cfg.green_shift;
    assign blue_v  = in_src & cfg.blue_mask;

    always_comb begin
        data_next.sel       = SEL_DIRECT;
        data_next.we        = 1'b0;
        data_next.direct_px = in_dst;
        data_next.spread_d  = {in_dst, in_dst} & cfg.spread_mask;
        data_next.spread_s  = {in_src, in_src} & cfg.spread_mask;
        data_next.wgt_d     = 16'd0;
        data_next.wgt_s     = 6'd0;
        data_next.gray_sum  = {4'b0, red_v} * 20'd3 + {4'b0, green_v} * 20'd6
                            + {4'b0, blue_v};
        case (op_t'(in_op))
            OP_ALPHA, OP_SINGLE: begin
                if (in_alpha != ALPHA_KEEP && !keyed) begin
                    data_next.we = 1'b1;
                    if (in_alpha == 5'd0 ||
                        (op_t'(in_op) == OP_SINGLE && in_src != cfg.blend_color)) begin
                        data_next.direct_px = in_src;
                    end else begin
                        data_next.sel   = SEL_BLEND;
                        data_next.wgt_d = {11'b0, in_alpha};
                        data_next.wgt_s = ALPHA_FULL - {1'b0, in_alpha};
                    end
                end
            end
            OP_LIGHT: begin
                // Blend toward black: the source term weighs nothing
                data_next.we    = 1'b1;
                data_next.sel   = SEL_BLEND;
                data_next.wgt_d = in_src & cfg.blue_mask;
            end
            OP_ADD: begin
                if (!keyed) begin
                    data_next.we    = 1'b1;
                    data_next.sel   = SEL_ADD;
                    data_next.wgt_d = 16'd1;
                    data_next.wgt_s = 6'd1;
                end
            end
            OP_GRAY: begin
                if (!keyed) begin
                    data_next.we  = 1'b1;
                    data_next.sel = SEL_GRAY;
                end
            end
            OP_FILL: begin
                if (in_src != cfg.src_key) begin
                    data_next.we        = 1'b1;
                    data_next.direct_px = cfg.blend_color;
                end
            end
            default: data_next.we = 1'b0;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/rgb_rop_mul.sv =====
// Stage 2: channel weighting products and the divide-by-ten reciprocal product.
module rgb_rop_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rgb_rop_pkg::prep_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rgb_rop_pkg::prod_t  out_data
);
    import rgb_rop_pkg::*;

    logic                              valid_reg;
    prod_t                             data_reg;
    prod_t                             data_next;
    logic [47:0]                       mul_d;
    logic [37:0]                       mul_s;
    logic [GRAY_SUM_W+GRAY_RCP_W-1:0]  mul_g;

    // Channel weighting products are kept modulo 2^32
    assign mul_d = in_data.spread_d * in_data.wgt_d;
    assign mul_s = in_data.spread_s * in_data.wgt_s;
    assign mul_g = in_data.gray_sum * GRAY_RCP;

    always_comb begin
        data_next.sel       = in_data.sel;
        data_next.we        = in_data.we;
        data_next.direct_px = in_data.direct_px;
        data_next.prod_d    = mul_d[31:0];
        data_next.prod_s    = mul_s[31:0];
        data_next.gray_t    = mul_g[GRAY_SHIFT +: 16];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/rgb_rop_fold.sv =====
// Stage 3: weighted sum, scale, fold back to 16 bits, gray pack, output register.
module rgb_rop_fold (
    input  logic                aclk,
    input  logic                aresetn,
    input  rgb_rop_pkg::cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  rgb_rop_pkg::prod_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_pixel,
    output logic                out_we
);
    import rgb_rop_pkg::*;

    logic        valid_reg;
    logic [15:0] pixel_reg;
    logic [15:0] pixel_next;
    logic        we_reg;
    logic [31:0] sum;
    logic [31:0] scaled;
    logic [31:0] masked;
    logic [15:0] folded;
    logic [15:0] gray_px;

    // Blend scales by 1/32, additive keeps the raw sum
    assign sum    = in_data.prod_d + in_data.prod_s;
    assign scaled = (in_data.sel == SEL_ADD) ? sum : (sum >> BLEND_SHIFT);
    assign masked = scaled & cfg.spread_mask;
    assign folded = masked[31:16] | masked[15:0];

    // Replicate the gray level into each channel position
    assign gray_px = (in_data.gray_t << cfg.red_shift) | (in_data.gray_t << cfg.green_shift)
                   | in_data.gray_t;

    always_comb begin
        case (in_data.sel)
            SEL_BLEND, SEL_ADD: pixel_next = folded;
            SEL_GRAY:           pixel_next = gray_px;
            default:            pixel_next = in_data.direct_px;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pixel_reg <= pixel_next;
            we_reg    <= in_data.we;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;
    assign out_we    = we_reg;

endmodule

// ===== rtl/rgb565_pixel_raster_op.sv =====
// Top level of the RGB565 pixel raster-op pipeline.
//
// Input stream: one transfer per pixel carrying source pixel, destination
// pixel and alpha on s_tdata and the operation code on s_tuser. Output
// stream: one transfer per input transfer, in order, with the new
// destination pixel on m_tdata and the write flag on m_tuser.
// An input transfer passes three registered stages (decode/spread,
// multiply, sum/fold/output register) on its way to m_tvalid.
// Throughput is one pixel per cycle while m_tready stays high.
// Each stage holds its item while the next one is full, so when the
// receiver drops m_tready the stages fill up one by one and s_tready falls
// only once all three hold data; nothing is lost or repeated.
// Reset clears all stage valid bits and loads the register defaults
// (RGB565 layout, no color key, blend color black).
// Configuration registers are to be written through cfg_wr_en/cfg_index/cfg_wdata
// by the user only while the pipeline is empty; the block does not enforce it.
module rgb565_pixel_raster_op (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // src_pixel[15:0], dst_pixel[31:16], alpha[36:32], zero
    input  logic [2:0]  s_tuser,   // op[2:0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_pixel[15:0]
    output logic [0:0]  m_tuser    // write_enable[0]
);
    import rgb_rop_pkg::*;

    cfg_t  cfg;
    prep_t prep_data;
    prod_t prod_data;
    logic  prep_valid;
    logic  prep_ready;
    logic  prod_valid;
    logic  prod_ready;
    logic  out_we;

    rgb_rop_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rgb_rop_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_src    (s_tdata[15:0]),
        .in_dst    (s_tdata[31:16]),
        .in_alpha  (s_tdata[36:32]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    rgb_rop_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    rgb_rop_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_we    (out_we)
    );

    assign m_tuser = out_we;

endmodule

// ===== rtl/rgb_rop_checker.sv =====
// Port-level checker for the raster-op block and its bind.
`include "rgb565_pixel_raster_op_macros.svh"

module rgb_rop_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result keeps its payload
    `ROP_ASSERT_RUN(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

    // Reset empties the pipeline
    `ROP_ASSERT_ALL(a_reset_empty, aclk, (!aresetn) |=> (!m_tvalid && s_tready), "pipeline not empty after reset")

    // With the receiver ready, an accepted transfer passes the decode, multiply and fold stage registers onto m_tvalid
    `ROP_ASSERT_RUN(a_latency, aclk, aresetn, (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid, "result missing after pipeline latency")

    // Input side is only held off while a result is waiting
    `ROP_ASSERT_RUN(a_ready_stall, aclk, aresetn, (!s_tready) |-> (m_tvalid && !m_tready), "input stalled without output backpressure")

endmodule

bind rgb565_pixel_raster_op rgb_rop_checker u_rgb_rop_checker (.*);
